// ===== hdl/ray_collision_time_assert.svh =====
// assertion macros for the ray collision time block
`ifndef RAY_COLLISION_TIME_ASSERT_SVH
`define RAY_COLLISION_TIME_ASSERT_SVH
`ifndef SYNTHESIS
`define RCT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define RCT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RCT_ASSERT(lbl, prop, msg)
`define RCT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== hdl/rct_pkg.sv =====
`default_nettype none
package rct_pkg;

	typedef struct packed {
		logic seg;
		logic overlap;
		logic miss;
	} ctl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	typedef enum logic [1:0] {
		CLS_FINITE = 2'd0,
		CLS_PINF   = 2'd1,
		CLS_MINF   = 2'd2
	} class_t;

	localparam int HIT_W = 32;
	localparam int QUOT_W = HIT_W - 1;
	localparam logic [HIT_W-1:0] HIT_MAX = {1'b0, {QUOT_W{1'b1}}};
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

endpackage
`default_nettype wire

// ===== hdl/rct_channels.sv =====
`default_nettype none
interface rct_req_if #(parameter int COORD_WIDTH = 24);
	logic valid;
	logic ready;
	logic kind;
	logic signed [COORD_WIDTH-1:0] origin_x;
	logic signed [COORD_WIDTH-1:0] origin_y;
	logic signed [COORD_WIDTH-1:0] vel_x;
	logic signed [COORD_WIDTH-1:0] vel_y;
	logic signed [COORD_WIDTH-1:0] point_a_x;
	logic signed [COORD_WIDTH-1:0] point_a_y;
	logic signed [COORD_WIDTH-1:0] point_b_x;
	logic signed [COORD_WIDTH-1:0] point_b_y;
	logic [COORD_WIDTH-2:0] radius;
	logic inside_req;

	modport source(output valid, kind, origin_x, origin_y, vel_x, vel_y, point_a_x,
		point_a_y, point_b_x, point_b_y, radius, inside_req, input ready);
	modport sink(input valid, kind, origin_x, origin_y, vel_x, vel_y, point_a_x,
		point_a_y, point_b_x, point_b_y, radius, inside_req, output ready);
endinterface

interface rct_rsp_if;
	logic valid;
	logic ready;
	logic signed [rct_pkg::HIT_W-1:0] hit_time;
	logic [1:0] time_class;

	modport source(output valid, hit_time, time_class, input ready);
	modport sink(input valid, hit_time, time_class, output ready);
endinterface
`default_nettype wire

// ===== hdl/rct_front.sv =====
`default_nettype none
module rct_front #(
	parameter int COORD_WIDTH = 24,
	localparam int AW = 2 * COORD_WIDTH + 4,
	localparam int PW = 4 * COORD_WIDTH - 2
) (
	input wire logic clk,
	input wire logic arst_n,
	rct_req_if.sink req,
	input rct_pkg::qstat_t qstat,
	output logic push,
	output rct_pkg::ctl_t ent_ctl,
	output logic [PW-1:0] ent_disc,
	output logic signed [AW-1:0] ent_num,
	output logic [AW-1:0] ent_den
);
	localparam int W = COORD_WIDTH;
	localparam int D = W + 1;
	localparam int CA = 2 * D;
	localparam int C2 = 4 * D;
	localparam int RV = 4 * W;
	localparam int XW = 4 * D + 1;

	logic fen;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic signed [D-1:0] fx_s1, fy_s1, ex_s1, ey_s1;
	logic signed [W-1:0] vx_s1, vy_s1;
	logic [W-2:0] rad_s1;
	rct_pkg::ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6;

	logic signed [2*W:0] vxfy_s2, vyfx_s2, vxfx_s2, vyfy_s2, vxey_s2, vyex_s2;
	logic signed [2*W-1:0] vxvx_s2, vyvy_s2;
	logic [2*W-3:0] rr_s2, rr_s3;
	logic signed [2*D-1:0] fxey_s2, fyex_s2;

	logic signed [AW-1:0] cr_s3, dot_s3, den_s3, tn_s3;
	logic [2*W-1:0] vv_s3, vv_s4, vv_s5;

	logic [CA-1:0] cr_abs;
	logic [D-1:0] crh, crl;
	logic [W-1:0] rrh, rrl, vvh, vvl;
	logic [CA-1:0] cll_s4, chl_s4, chh_s4;
	logic [2*W-1:0] rll_s4, rlh_s4, rhl_s4, rhh_s4;
	logic signed [AW-1:0] sden_s4, stn_s4, ssn_s4, dot_s4;
	logic szero_s4;

	logic [C2-1:0] cr2_s5;
	logic [RV-1:0] r2vv_s5;
	logic signed [AW-1:0] sden_s5, stn_s5, dot_s5;
	logic smiss_s5;

	logic signed [XW-1:0] disc_full;
	logic dpos;
	logic [PW-1:0] disc_s6;
	logic signed [AW-1:0] num_s6;
	logic [AW-1:0] den_s6;

	assign fen = !(v_s6 && qstat.full);
	assign req.ready = fen;
	assign push = v_s6 && !qstat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (fen) begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	assign cr_abs = cr_s3[AW-1] ? CA'(-cr_s3) : CA'(cr_s3);
	assign crh = cr_abs[CA-1:D];
	assign crl = cr_abs[D-1:0];
	assign rrh = W'(rr_s3[2*W-3:W]);
	assign rrl = rr_s3[W-1:0];
	assign vvh = vv_s3[2*W-1:W];
	assign vvl = vv_s3[W-1:0];

	assign disc_full = $signed(XW'(r2vv_s5)) - $signed(XW'(cr2_s5));
	assign dpos = !disc_full[XW-1] && (disc_full != '0);

	always_ff @(posedge clk) begin
		if (fen) begin
			// differences
			fx_s1 <= {req.point_a_x[W-1], req.point_a_x} - {req.origin_x[W-1], req.origin_x};
			fy_s1 <= {req.point_a_y[W-1], req.point_a_y} - {req.origin_y[W-1], req.origin_y};
			ex_s1 <= {req.point_b_x[W-1], req.point_b_x} - {req.point_a_x[W-1], req.point_a_x};
			ey_s1 <= {req.point_b_y[W-1], req.point_b_y} - {req.point_a_y[W-1], req.point_a_y};
			vx_s1 <= req.vel_x;
			vy_s1 <= req.vel_y;
			rad_s1 <= req.radius;
			ctl_s1 <= '{seg: req.kind, overlap: req.inside_req, miss: 1'b0};

			// products
			vxfy_s2 <= vx_s1 * fy_s1;
			vyfx_s2 <= vy_s1 * fx_s1;
			vxfx_s2 <= vx_s1 * fx_s1;
			vyfy_s2 <= vy_s1 * fy_s1;
			vxey_s2 <= vx_s1 * ey_s1;
			vyex_s2 <= vy_s1 * ex_s1;
			vxvx_s2 <= vx_s1 * vx_s1;
			vyvy_s2 <= vy_s1 * vy_s1;
			rr_s2 <= rad_s1 * rad_s1;
			fxey_s2 <= fx_s1 * ey_s1;
			fyex_s2 <= fy_s1 * ex_s1;
			ctl_s2 <= ctl_s1;

			// cross and dot products
			cr_s3 <= AW'(vxfy_s2) - AW'(vyfx_s2);
			dot_s3 <= AW'(vxfx_s2) + AW'(vyfy_s2);
			den_s3 <= AW'(vxey_s2) - AW'(vyex_s2);
			tn_s3 <= AW'(fxey_s2) - AW'(fyex_s2);
			vv_s3 <= $unsigned(vxvx_s2) + $unsigned(vyvy_s2);
			rr_s3 <= rr_s2;
			ctl_s3 <= ctl_s2;

			// partial products of the wide squares, segment sign fold
			cll_s4 <= crl * crl;
			chl_s4 <= crh * crl;
			chh_s4 <= crh * crh;
			rll_s4 <= rrl * vvl;
			rlh_s4 <= rrl * vvh;
			rhl_s4 <= rrh * vvl;
			rhh_s4 <= rrh * vvh;
			sden_s4 <= den_s3[AW-1] ? -den_s3 : den_s3;
			stn_s4 <= den_s3[AW-1] ? -tn_s3 : tn_s3;
			ssn_s4 <= den_s3[AW-1] ? cr_s3 : -cr_s3;
			szero_s4 <= den_s3 == '0;
			dot_s4 <= dot_s3;
			vv_s4 <= vv_s3;
			ctl_s4 <= ctl_s3;

			cr2_s5 <= {chh_s4, {CA{1'b0}}} + (C2'(chl_s4) << (D + 1)) + C2'(cll_s4);
			r2vv_s5 <= {rhh_s4, {(2 * W){1'b0}}} + ((RV'(rhl_s4) + RV'(rlh_s4)) << W)
				+ RV'(rll_s4);
			smiss_s5 <= szero_s4 || stn_s4[AW-1] || ssn_s4[AW-1] || (sden_s4 < ssn_s4);
			sden_s5 <= sden_s4;
			stn_s5 <= stn_s4;
			dot_s5 <= dot_s4;
			vv_s5 <= vv_s4;
			ctl_s5 <= ctl_s4;

			ctl_s6 <= '{seg: ctl_s5.seg, overlap: ctl_s5.overlap,
				miss: ctl_s5.seg ? smiss_s5 : !dpos};
			disc_s6 <= ctl_s5.seg ? '0 : disc_full[PW-1:0];
			num_s6 <= ctl_s5.seg ? stn_s5 : dot_s5;
			den_s6 <= ctl_s5.seg ? $unsigned(sden_s5) : AW'(vv_s5);
		end
	end

	assign ent_ctl = ctl_s6;
	assign ent_disc = disc_s6;
	assign ent_num = num_s6;
	assign ent_den = den_s6;
endmodule
`default_nettype wire

// ===== hdl/rct_queue.sv =====
`default_nettype none
module rct_queue #(
	parameter int DATA_W = 300
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input rct_pkg::ctl_t push_ctl,
	input wire logic [DATA_W-1:0] push_data,
	input wire logic pop,
	output rct_pkg::ctl_t head_ctl,
	output logic [DATA_W-1:0] head_data,
	output rct_pkg::qstat_t qstat
);
	localparam int QA = rct_pkg::QUEUE_AW;

	logic [DATA_W-1:0] data_q [rct_pkg::QUEUE_DEPTH];
	rct_pkg::ctl_t ctl_q [rct_pkg::QUEUE_DEPTH];
	logic [QA-1:0] wr_q, rd_q;
	logic [QA:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (!push && pop) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_q] <= push_data;
			ctl_q[wr_q] <= push_ctl;
		end
	end

	assign head_ctl = ctl_q[rd_q];
	assign head_data = data_q[rd_q];
	assign qstat.full = cnt_q == (QA + 1)'(rct_pkg::QUEUE_DEPTH);
	assign qstat.empty = cnt_q == '0;
endmodule
`default_nettype wire

// ===== hdl/rct_back.sv =====
`default_nettype none
module rct_back #(
	parameter int COORD_WIDTH = 24,
	parameter int TIME_FRAC = 16,
	localparam int AW = 2 * COORD_WIDTH + 4,
	localparam int PW = 4 * COORD_WIDTH - 2
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic head_valid,
	input rct_pkg::ctl_t head_ctl,
	input wire logic [PW-1:0] head_disc,
	input wire logic signed [AW-1:0] head_num,
	input wire logic [AW-1:0] head_den,
	output logic pop,
	rct_rsp_if.source rsp
);
	localparam int RW = PW / 2;
	localparam int XP = PW + 1;
	localparam int CW = AW + 32;
	localparam int QW = rct_pkg::QUOT_W;

	logic en;

	logic sq_v_s [RW+1];
	rct_pkg::ctl_t sq_ctl_s [RW+1];
	logic [PW-1:0] sq_rem_s [RW+1];
	logic [RW-1:0] sq_root_s [RW+1];
	logic signed [AW-1:0] sq_num_s [RW+1];
	logic [AW-1:0] sq_den_s [RW+1];

	logic exact;
	logic signed [AW:0] num_x, root_x, root_up, nsum;
	logic v_s1;
	rct_pkg::ctl_t ctl_s1;
	logic [AW-1:0] num_s1, den_s1;

	logic [CW-1:0] nshift, dlim;

	logic dv_v_s [QW+1];
	rct_pkg::ctl_t dv_ctl_s [QW+1];
	logic [CW-1:0] dv_rem_s [QW+1];
	logic [AW-1:0] dv_den_s [QW+1];
	logic [QW-1:0] dv_q_s [QW+1];
	logic dv_sat_s [QW+1];

	assign en = !rsp.valid || rsp.ready;
	assign pop = en && head_valid;

	// square root entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sq_v_s[0] <= 1'b0;
		else if (en) sq_v_s[0] <= head_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_ctl_s[0] <= head_ctl;
			sq_rem_s[0] <= head_disc;
			sq_root_s[0] <= '0;
			sq_num_s[0] <= head_num;
			sq_den_s[0] <= head_den;
		end
	end

	// one root bit per stage
	for (genvar i = 0; i < RW; i++) begin : g_sqrt
		localparam int K = RW - 1 - i;
		logic [XP-1:0] trial;
		logic take;

		assign trial = (XP'(sq_root_s[i]) << (K + 1)) | (XP'(1) << (2 * K));
		assign take = {1'b0, sq_rem_s[i]} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_v_s[i+1] <= 1'b0;
			else if (en) sq_v_s[i+1] <= sq_v_s[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_ctl_s[i+1] <= sq_ctl_s[i];
				sq_rem_s[i+1] <= take ? PW'({1'b0, sq_rem_s[i]} - trial) : sq_rem_s[i];
				sq_root_s[i+1] <= sq_root_s[i] | (take ? (RW'(1) << K) : '0);
				sq_num_s[i+1] <= sq_num_s[i];
				sq_den_s[i+1] <= sq_den_s[i];
			end
		end
	end

	// root selection: floor for the exit root, ceiling for the entry root
	assign exact = sq_rem_s[RW] == '0;
	assign num_x = (AW + 1)'(sq_num_s[RW]);
	assign root_x = $signed((AW + 1)'(sq_root_s[RW]));
	assign root_up = root_x + $signed((AW + 1)'(!exact));
	assign nsum = sq_ctl_s[RW].seg ? num_x :
		(sq_ctl_s[RW].overlap ? num_x + root_x : num_x - root_up);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= sq_v_s[RW];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1 <= '{seg: sq_ctl_s[RW].seg, overlap: sq_ctl_s[RW].overlap,
				miss: sq_ctl_s[RW].miss || (!sq_ctl_s[RW].seg && nsum[AW])};
			num_s1 <= nsum[AW-1:0];
			den_s1 <= sq_den_s[RW];
		end
	end

	// saturation test and divider entry
	assign nshift = CW'(num_s1) << TIME_FRAC;
	assign dlim = CW'(den_s1) << QW;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_v_s[0] <= 1'b0;
		else if (en) dv_v_s[0] <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_ctl_s[0] <= ctl_s1;
			dv_rem_s[0] <= nshift;
			dv_den_s[0] <= den_s1;
			dv_q_s[0] <= '0;
			dv_sat_s[0] <= nshift >= dlim;
		end
	end

	// one quotient bit per stage
	for (genvar j = 0; j < QW; j++) begin : g_div
		localparam int K = QW - 1 - j;
		logic [CW-1:0] sub;
		logic take;

		assign sub = CW'(dv_den_s[j]) << K;
		assign take = dv_rem_s[j] >= sub;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v_s[j+1] <= 1'b0;
			else if (en) dv_v_s[j+1] <= dv_v_s[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_ctl_s[j+1] <= dv_ctl_s[j];
				dv_rem_s[j+1] <= take ? dv_rem_s[j] - sub : dv_rem_s[j];
				dv_den_s[j+1] <= dv_den_s[j];
				dv_q_s[j+1] <= dv_q_s[j] | (take ? (QW'(1) << K) : '0);
				dv_sat_s[j+1] <= dv_sat_s[j];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rsp.valid <= 1'b0;
		else if (en) rsp.valid <= dv_v_s[QW];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (dv_ctl_s[QW].miss) begin
				rsp.hit_time <= '0;
				rsp.time_class <= dv_ctl_s[QW].overlap ? rct_pkg::CLS_MINF : rct_pkg::CLS_PINF;
			end else begin
				rsp.hit_time <= dv_sat_s[QW] ? rct_pkg::HIT_MAX : {1'b0, dv_q_s[QW]};
				rsp.time_class <= rct_pkg::CLS_FINITE;
			end
		end
	end
endmodule
`default_nettype wire

// ===== hdl/ray_collision_time.sv =====
// throughput: one item per cycle while the result side keeps up
// latency is set by the square root (one root bit per stage) and the 31-stage divider
// a four-entry queue separates setup arithmetic from the root and divide pipeline
// reset: arst_n clears all valid bits and queue pointers; data registers are not reset
`default_nettype none
module ray_collision_time #(
	parameter int COORD_WIDTH = 24,
	parameter int TIME_FRAC = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	rct_req_if.sink req,
	rct_rsp_if.source rsp
);
	localparam int AW = 2 * COORD_WIDTH + 4;
	localparam int PW = 4 * COORD_WIDTH - 2;
	localparam int DW = PW + 2 * AW;

	logic push, pop;
	rct_pkg::ctl_t ent_ctl, head_ctl;
	rct_pkg::qstat_t qstat;
	logic [PW-1:0] ent_disc, head_disc;
	logic signed [AW-1:0] ent_num, head_num;
	logic [AW-1:0] ent_den, head_den;
	logic [DW-1:0] head_data;

	rct_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.qstat(qstat),
		.push(push),
		.ent_ctl(ent_ctl),
		.ent_disc(ent_disc),
		.ent_num(ent_num),
		.ent_den(ent_den)
	);

	rct_queue #(.DATA_W(DW)) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_ctl(ent_ctl),
		.push_data({ent_disc, ent_num, ent_den}),
		.pop(pop),
		.head_ctl(head_ctl),
		.head_data(head_data),
		.qstat(qstat)
	);

	assign head_disc = head_data[DW-1:2*AW];
	assign head_num = head_data[2*AW-1:AW];
	assign head_den = head_data[AW-1:0];

	rct_back #(.COORD_WIDTH(COORD_WIDTH), .TIME_FRAC(TIME_FRAC)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(!qstat.empty),
		.head_ctl(head_ctl),
		.head_disc(head_disc),
		.head_num(head_num),
		.head_den(head_den),
		.pop(pop),
		.rsp(rsp)
	);

`include "ray_collision_time_assert.svh"

	`RCT_ASSERT(a_inf_zero, rsp.valid && (rsp.time_class != rct_pkg::CLS_FINITE) |-> (rsp.hit_time == '0), "non-finite result with nonzero time")
	`RCT_ASSERT(a_stall_full, !req.ready |-> qstat.full, "input stalled while queue has room")
	`RCT_ASSERT(a_pop_empty, pop |-> !qstat.empty, "pop from empty queue")
	`RCT_ASSERT_ALWAYS(a_reset_idle, !arst_n |=> !rsp.valid, "result valid after reset")
endmodule
`default_nettype wire
